[hw/rtl/ugtb_pkg.sv]
// Shared constants, codes and item types of the triangle binning block.
package ugtb_pkg;

    localparam int GRID_RES_DEF      = 32;
    localparam int MAX_TRIANGLES_DEF = 1024;
    localparam int MAX_INDICES_DEF   = 65536;

    // Box padding: 0.05 in Q16.16.
    localparam int PAD_Q16 = 3277;

    localparam int COORD_W   = 32;
    localparam int ADDR_W    = 16;
    localparam int ACT_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int OSTART_W  = 17;
    localparam int OCOUNT_W  = 11;
    localparam int OTIDX_W   = 10;
    localparam int OTOTAL_W  = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ_CELL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_LIST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_ADDR  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_BUILT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
        logic [ADDR_W-1:0]         address;
    } ugtb_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSTART_W-1:0] cell_start;
        logic [OCOUNT_W-1:0] cell_count;
        logic [OTIDX_W-1:0]  triangle_index;
        logic [OTOTAL_W-1:0] total_indices;
    } ugtb_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MM,
        ST_LD_PREP,
        ST_LD_DIV,
        ST_LD_WR,
        ST_BLD_CLR,
        ST_WLK_TRI,
        ST_WLK_SPAN,
        ST_WLK_RD,
        ST_WLK_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_Q_RD,
        ST_Q_DATA,
        ST_RESP
    } ugtb_state_t;

endpackage

[hw/rtl/uniform_grid_triangle_binning.sv]
// Top level of the uniform grid triangle binning block.
//
// Usage: configure the six box registers (signed Q16.16) through the plain
// write port while the block is idle, then send items on the s_ channel.
// Every item (load, build, cell read, list read, clear) gives exactly one
// result item on the m_ channel, in order.
// A load passes through the accept cycle, the min/max and setup steps,
// one restoring-division step per cycle for all six range bounds in
// parallel, one write of the range memory and the response cycle; cell
// and list reads pass through a memory read, while clear and unused
// actions go straight to the response. A build runs a count-clear sweep
// and a prefix sweep over the cell memories, and a count walk and a fill
// walk over the triangles, in which each cell update is a read, then a write.
// One item is in work at a time; a new item is taken once the previous
// result sits in the output register, so a stalled receiver only holds
// the block when a second result is ready.
// Reset clears the counts and flags and returns the box registers to the
// unit box; no memory clearing pass runs after reset, since a build sweeps
// the count memory before use.
module uniform_grid_triangle_binning
    import ugtb_pkg::*;
#(
    parameter int GRID_RES      = GRID_RES_DEF,
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int MAX_INDICES   = MAX_INDICES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ugtb_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ugtb_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_W-1:0]    cfg_wdata
);

    localparam int NUM_CELLS = GRID_RES * GRID_RES * GRID_RES;
    localparam int CELL_AW   = $clog2(NUM_CELLS);
    localparam int QB        = $clog2(GRID_RES);
    localparam int TCNT_W    = $clog2(MAX_TRIANGLES + 1);
    localparam int TRI_AW    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CNT_W     = TCNT_W;
    localparam int RUN_W     = TCNT_W + CELL_AW;
    localparam int TOT_W     = $clog2(MAX_INDICES + 1);
    localparam int LIST_AW   = $clog2(MAX_INDICES);
    localparam int D_W       = COORD_W + 3;
    localparam int NUM_W     = D_W + QB;
    localparam int RNG_W     = 6 * QB + 1;
    localparam int STEP_W    = $clog2(QB + 1);

    localparam logic signed [D_W-1:0] PAD_EXT = D_W'(PAD_Q16);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    ugtb_state_t state_reg, state_next;
    ugtb_in_t    item_reg;
    ugtb_out_t   res_reg, res_next;
    ugtb_out_t   m_data_reg, m_data_next;
    logic        m_valid_reg, m_valid_next;

    logic signed [COORD_W-1:0] box_min_reg [3];
    logic signed [COORD_W-1:0] box_max_reg [3];

    logic [TCNT_W-1:0]  tri_cnt_reg, tri_cnt_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic               built_reg, built_next;
    logic               ovf_reg, ovf_next;

    logic [CELL_AW-1:0] idx_reg, idx_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [TCNT_W-1:0]  t_reg, t_next;
    logic               pass_reg, pass_next;
    logic [QB-1:0]      x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [QB-1:0]      lo_reg [3];
    logic [QB-1:0]      hi_reg [3];

    // Load datapath: per-axis bounds, then six lanes (three low, three high).
    logic signed [COORD_W-1:0] mn_reg [3];
    logic signed [COORD_W-1:0] mx_reg [3];
    logic signed [D_W-1:0]     ext_reg [3];
    logic signed [D_W-1:0]     gmin_reg [3];
    logic [NUM_W-1:0]          dvs_reg [3];
    logic [NUM_W-1:0]          rem_reg [6];
    logic [QB-1:0]             q_reg [6];
    logic                      neg_reg [6];
    logic                      over_reg [6];
    logic [STEP_W-1:0]         step_reg;

    // ---------------------------------------------------------------------
    // Memories and their ports
    // ---------------------------------------------------------------------
    logic [RNG_W-1:0]   rng_mem [MAX_TRIANGLES];
    logic [CNT_W-1:0]   cnt_mem [NUM_CELLS];
    logic [RUN_W-1:0]   st_mem  [NUM_CELLS];
    logic [CNT_W-1:0]   off_mem [NUM_CELLS];
    logic [TRI_AW-1:0]  lst_mem [MAX_INDICES];

    logic [RNG_W-1:0]   rng_rd;
    logic [CNT_W-1:0]   cnt_rd;
    logic [RUN_W-1:0]   st_rd;
    logic [CNT_W-1:0]   off_rd;
    logic [TRI_AW-1:0]  lst_rd;

    logic [TRI_AW-1:0]  rng_addr;
    logic               rng_we;
    logic [RNG_W-1:0]   rng_wdata;
    logic [CELL_AW-1:0] cell_idx;
    logic               cnt_we, st_we, off_we, lst_we;
    logic [CNT_W-1:0]   cnt_wdata, off_wdata;
    logic [RUN_W-1:0]   st_wdata;
    logic [LIST_AW-1:0] lst_waddr, lst_raddr;
    logic [TRI_AW-1:0]  lst_wdata;

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] min3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic logic signed [COORD_W-1:0] max3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    logic signed [COORD_W-1:0] vtx [3][3];
    assign vtx[0][0] = item_reg.v0_x;
    assign vtx[0][1] = item_reg.v0_y;
    assign vtx[0][2] = item_reg.v0_z;
    assign vtx[1][0] = item_reg.v1_x;
    assign vtx[1][1] = item_reg.v1_y;
    assign vtx[1][2] = item_reg.v1_z;
    assign vtx[2][0] = item_reg.v2_x;
    assign vtx[2][1] = item_reg.v2_y;
    assign vtx[2][2] = item_reg.v2_z;

    // Offset of each lane bound from the padded grid origin.
    logic signed [D_W-1:0] lane_d [6];
    logic [NUM_W:0]        lane_trial [6];
    logic [RNG_W-1:0]      span_w;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lane_d[a]     = D_W'(mn_reg[a]) - gmin_reg[a];
            lane_d[a + 3] = D_W'(mx_reg[a]) - gmin_reg[a];
            lane_trial[a]     = {1'b0, rem_reg[a]} - {1'b0, dvs_reg[a]};
            lane_trial[a + 3] = {1'b0, rem_reg[a + 3]} - {1'b0, dvs_reg[a]};
        end
    end

    // Clamp the quotients into a cell range per axis; any axis whose range
    // comes out empty (or an inverted box) marks the whole triangle empty.
    always_comb begin
        logic          empty;
        logic [QB-1:0] lo_q;
        logic [QB-1:0] hi_q;
        empty  = 1'b0;
        span_w = '0;
        for (int a = 0; a < 3; a++) begin
            lo_q = neg_reg[a] ? '0 : q_reg[a];
            hi_q = over_reg[a + 3] ? QB'(GRID_RES - 1) : q_reg[a + 3];
            if (ext_reg[a] <= 0 || over_reg[a] || neg_reg[a + 3] || lo_q > hi_q) begin
                empty = 1'b1;
            end
            span_w[a * QB +: QB]       = lo_q;
            span_w[(a + 3) * QB +: QB] = hi_q;
        end
        span_w[6 * QB] = empty;
    end

    logic [CELL_AW-1:0] cell_walk;
    assign cell_walk = CELL_AW'(x_reg)
                     + CELL_AW'(y_reg) * CELL_AW'(GRID_RES)
                     + CELL_AW'(z_reg) * CELL_AW'(GRID_RES * GRID_RES);

    logic [RUN_W:0] fill_pos;
    assign fill_pos = {1'b0, st_rd} + (RUN_W + 1)'(off_rd);

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign lst_raddr = LIST_AW'(item_reg.address);

    logic accept;
    assign accept = s_valid && s_ready;

    // ---------------------------------------------------------------------
    // Sequencer: next state, memory controls and result
    // ---------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        tri_cnt_next = tri_cnt_reg;
        total_next   = total_reg;
        built_next   = built_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        run_next     = run_reg;
        t_next       = t_reg;
        pass_next    = pass_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;

        rng_we    = 1'b0;
        rng_wdata = span_w;
        rng_addr  = t_reg[TRI_AW-1:0];
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        st_we     = 1'b0;
        st_wdata  = run_reg;
        off_we    = 1'b0;
        off_wdata = '0;
        lst_we    = 1'b0;
        lst_waddr = fill_pos[LIST_AW-1:0];
        lst_wdata = t_reg[TRI_AW-1:0];
        cell_idx  = CELL_AW'(item_reg.address);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    state_next = ST_RESP;
                    case (s_data.action)
                        ACT_LOAD: begin
                            if (tri_cnt_reg >= TCNT_W'(MAX_TRIANGLES)) begin
                                res_next.status = STS_FULL;
                            end else begin
                                state_next = ST_LD_MM;
                            end
                        end
                        ACT_BUILD: begin
                            total_next = '0;
                            ovf_next   = 1'b0;
                            idx_next   = '0;
                            state_next = ST_BLD_CLR;
                        end
                        ACT_READ_CELL, ACT_READ_LIST: begin
                            if (!built_reg) begin
                                res_next.status = STS_NOT_BUILT;
                            end else if ((s_data.action == ACT_READ_CELL)
                                ? (32'(s_data.address) >= NUM_CELLS)
                                : ((ADDR_W + TOT_W)'(s_data.address)
                                   >= (ADDR_W + TOT_W)'(total_reg))) begin
                                res_next.status = STS_BAD_ADDR;
                            end else begin
                                state_next = ST_Q_RD;
                            end
                        end
                        ACT_CLEAR: begin
                            tri_cnt_next = '0;
                            total_next   = '0;
                            built_next   = 1'b0;
                            ovf_next     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_LD_MM:   state_next = ST_LD_PREP;
            ST_LD_PREP: state_next = ST_LD_DIV;

            ST_LD_DIV: begin
                if (step_reg == STEP_W'(QB - 1)) begin
                    state_next = ST_LD_WR;
                end
            end

            ST_LD_WR: begin
                rng_we   = 1'b1;
                rng_addr = tri_cnt_reg[TRI_AW-1:0];
                res_next.triangle_index = OTIDX_W'(tri_cnt_reg);
                tri_cnt_next = tri_cnt_reg + 1'b1;
                built_next   = 1'b0;
                state_next   = ST_RESP;
            end

            // Zero the count memory, one cell a cycle.
            ST_BLD_CLR: begin
                cell_idx = idx_reg;
                cnt_we   = 1'b1;
                if (idx_reg == CELL_AW'(NUM_CELLS - 1)) begin
                    t_next     = '0;
                    pass_next  = 1'b0;
                    state_next = ST_WLK_TRI;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_WLK_TRI: begin
                if (t_reg >= tri_cnt_reg) begin
                    if (!pass_reg) begin
                        idx_next   = '0;
                        run_next   = '0;
                        state_next = ST_PFX_RD;
                    end else begin
                        built_next      = 1'b1;
                        res_next.status = ovf_reg ? STS_OVERFLOW : STS_OK;
                        state_next      = ST_RESP;
                    end
                end else begin
                    state_next = ST_WLK_SPAN;
                end
            end

            ST_WLK_SPAN: begin
                if (rng_rd[6 * QB]) begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_WLK_TRI;
                end else begin
                    x_next     = rng_rd[0 +: QB];
                    y_next     = rng_rd[QB +: QB];
                    z_next     = rng_rd[2 * QB +: QB];
                    state_next = ST_WLK_RD;
                end
            end

            ST_WLK_RD: begin
                cell_idx   = cell_walk;
                state_next = ST_WLK_WR;
            end

            ST_WLK_WR: begin
                cell_idx = cell_walk;
                if (!pass_reg) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd + 1'b1;
                    if (total_reg >= TOT_W'(MAX_INDICES)) begin
                        ovf_next = 1'b1;
                    end else begin
                        total_next = total_reg + 1'b1;
                    end
                end else begin
                    lst_we    = (fill_pos < MAX_INDICES);
                    off_we    = 1'b1;
                    off_wdata = off_rd + 1'b1;
                end
                state_next = ST_WLK_RD;
                if (x_reg != hi_reg[0]) begin
                    x_next = x_reg + 1'b1;
                end else if (y_reg != hi_reg[1]) begin
                    x_next = lo_reg[0];
                    y_next = y_reg + 1'b1;
                end else if (z_reg != hi_reg[2]) begin
                    x_next = lo_reg[0];
                    y_next = lo_reg[1];
                    z_next = z_reg + 1'b1;
                end else begin
                    t_next     = t_reg + 1'b1;
                    state_next = ST_WLK_TRI;
                end
            end

            ST_PFX_RD: begin
                cell_idx   = idx_reg;
                state_next = ST_PFX_WR;
            end

            // Exclusive prefix sum; the fill offsets are zeroed on the way.
            ST_PFX_WR: begin
                cell_idx = idx_reg;
                st_we    = 1'b1;
                off_we   = 1'b1;
                run_next = run_reg + RUN_W'(cnt_rd);
                if (idx_reg == CELL_AW'(NUM_CELLS - 1)) begin
                    t_next     = '0;
                    pass_next  = 1'b1;
                    state_next = ST_WLK_TRI;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_PFX_RD;
                end
            end

            ST_Q_RD: state_next = ST_Q_DATA;

            ST_Q_DATA: begin
                res_next.status = ovf_reg ? STS_OVERFLOW : STS_OK;
                if (item_reg.action == ACT_READ_CELL) begin
                    res_next.cell_start = OSTART_W'(st_rd);
                    res_next.cell_count = OCOUNT_W'(cnt_rd);
                end else begin
                    res_next.triangle_index = OTIDX_W'(lst_rd);
                end
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next = res_reg;
                    m_data_next.total_indices = OTOTAL_W'(total_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tri_cnt_reg <= '0;
            total_reg   <= '0;
            built_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            run_reg     <= '0;
            t_reg       <= '0;
            pass_reg    <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            for (int a = 0; a < 3; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= 32'sd65536;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tri_cnt_reg <= tri_cnt_next;
            total_reg   <= total_next;
            built_reg   <= built_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            t_reg       <= t_next;
            pass_reg    <= pass_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BOX_MIN_X: box_min_reg[0] <= cfg_wdata;
                    CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_wdata;
                    CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_wdata;
                    CFG_BOX_MAX_X: box_max_reg[0] <= cfg_wdata;
                    CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_wdata;
                    CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload and load datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (accept) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_WLK_SPAN) begin
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= rng_rd[a * QB +: QB];
                hi_reg[a] <= rng_rd[(a + 3) * QB +: QB];
            end
        end
        if (state_reg == ST_LD_MM) begin
            for (int a = 0; a < 3; a++) begin
                mn_reg[a]   <= min3(vtx[0][a], vtx[1][a], vtx[2][a]);
                mx_reg[a]   <= max3(vtx[0][a], vtx[1][a], vtx[2][a]);
                gmin_reg[a] <= D_W'(box_min_reg[a]) - PAD_EXT;
                ext_reg[a]  <= (D_W'(box_max_reg[a]) + PAD_EXT)
                             - (D_W'(box_min_reg[a]) - PAD_EXT);
            end
        end
        if (state_reg == ST_LD_PREP) begin
            step_reg <= '0;
            for (int a = 0; a < 3; a++) begin
                dvs_reg[a] <= NUM_W'(ext_reg[a]) << (QB - 1);
            end
            for (int j = 0; j < 6; j++) begin
                neg_reg[j]  <= lane_d[j] < 0;
                over_reg[j] <= lane_d[j] >= ext_reg[(j < 3) ? j : j - 3];
                q_reg[j]    <= '0;
                if (lane_d[j] >= 0 && lane_d[j] < ext_reg[(j < 3) ? j : j - 3]) begin
                    rem_reg[j] <= NUM_W'(lane_d[j]) * NUM_W'(GRID_RES);
                end else begin
                    rem_reg[j] <= '0;
                end
            end
        end
        // One restoring-division step per cycle in each of the six lanes.
        if (state_reg == ST_LD_DIV) begin
            step_reg <= step_reg + 1'b1;
            for (int a = 0; a < 3; a++) begin
                dvs_reg[a] <= dvs_reg[a] >> 1;
            end
            for (int j = 0; j < 6; j++) begin
                q_reg[j] <= (q_reg[j] << 1) | QB'(!lane_trial[j][NUM_W]);
                if (!lane_trial[j][NUM_W]) begin
                    rem_reg[j] <= lane_trial[j][NUM_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Memories with registered read data
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rng_we) begin
            rng_mem[rng_addr] <= rng_wdata;
        end
        rng_rd <= rng_mem[rng_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cell_idx] <= cnt_wdata;
        end
        cnt_rd <= cnt_mem[cell_idx];
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[cell_idx] <= st_wdata;
        end
        st_rd <= st_mem[cell_idx];
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[cell_idx] <= off_wdata;
        end
        off_rd <= off_mem[cell_idx];
    end

    always_ff @(posedge aclk) begin
        if (lst_we) begin
            lst_mem[lst_waddr] <= lst_wdata;
        end
        lst_rd <= lst_mem[lst_raddr];
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_tri_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tri_cnt_reg <= TCNT_W'(MAX_TRIANGLES))
        else $error("triangle count passed the store depth");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOT_W'(MAX_INDICES))
        else $error("index total passed its saturation value");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second item taken while one is in work");

    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) && state_reg != ST_IDLE |-> total_reg == TOT_W'(MAX_INDICES))
        else $error("overflow flagged below the index limit");

endmodule
